### hw/rtl/fppid_pkg.sv
`timescale 1ns / 1ps

package fppid_pkg;

   localparam int WORD_WIDTH    = 32;
   localparam int FRAC_BITS_DEF = 16;
   localparam int NUM_CSR       = 8;
   localparam int CSR_IDX_WIDTH = 3;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_FILTER_DECAY      = 3'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_INTEGRAL_GAIN     = 3'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_WINDUP_GAIN       = 3'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_FILTER_INPUT_GAIN = 3'd3;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_PROPORTIONAL_GAIN = 3'd4;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_DIRECT_DERIV_GAIN = 3'd5;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_DRIVE_MIN         = 3'd6;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_DRIVE_MAX         = 3'd7;

   localparam logic signed [WORD_WIDTH-1:0] DRIVE_MIN_RST = {1'b1, {(WORD_WIDTH-1){1'b0}}};
   localparam logic signed [WORD_WIDTH-1:0] DRIVE_MAX_RST = {1'b0, {(WORD_WIDTH-1){1'b1}}};

   typedef struct packed {
      logic signed [WORD_WIDTH-1:0] error_value;
      logic signed [WORD_WIDTH-1:0] measured_value;
   } req_word_type;

   typedef struct packed {
      logic signed [WORD_WIDTH-1:0] drive;
      logic                         limited;
   } rsp_word_type;

   typedef struct packed {
      logic signed [WORD_WIDTH-1:0] filter_decay;
      logic signed [WORD_WIDTH-1:0] integral_gain;
      logic signed [WORD_WIDTH-1:0] windup_gain;
      logic signed [WORD_WIDTH-1:0] filter_input_gain;
      logic signed [WORD_WIDTH-1:0] proportional_gain;
      logic signed [WORD_WIDTH-1:0] direct_derivative_gain;
      logic signed [WORD_WIDTH-1:0] drive_min;
      logic signed [WORD_WIDTH-1:0] drive_max;
   } cfg_type;

endpackage

### hw/rtl/fppid_csr.sv
`timescale 1ns / 1ps

module fppid_csr (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_we,
   input  logic [fppid_pkg::CSR_IDX_WIDTH-1:0]    csr_index,
   input  logic [fppid_pkg::WORD_WIDTH-1:0]       csr_wdata,
   output fppid_pkg::cfg_type                     cfg
);
   import fppid_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_FILTER_DECAY:      cfg_in.filter_decay           = csr_wdata;
            CSR_INTEGRAL_GAIN:     cfg_in.integral_gain          = csr_wdata;
            CSR_WINDUP_GAIN:       cfg_in.windup_gain            = csr_wdata;
            CSR_FILTER_INPUT_GAIN: cfg_in.filter_input_gain      = csr_wdata;
            CSR_PROPORTIONAL_GAIN: cfg_in.proportional_gain      = csr_wdata;
            CSR_DIRECT_DERIV_GAIN: cfg_in.direct_derivative_gain = csr_wdata;
            CSR_DRIVE_MIN:         cfg_in.drive_min              = csr_wdata;
            CSR_DRIVE_MAX:         cfg_in.drive_max              = csr_wdata;
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.filter_decay           <= '0;
         cfg_ff.integral_gain          <= '0;
         cfg_ff.windup_gain            <= '0;
         cfg_ff.filter_input_gain      <= '0;
         cfg_ff.proportional_gain      <= '0;
         cfg_ff.direct_derivative_gain <= '0;
         cfg_ff.drive_min              <= DRIVE_MIN_RST;
         cfg_ff.drive_max              <= DRIVE_MAX_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### hw/rtl/fppid_core.sv
`timescale 1ns / 1ps

module fppid_core #(
   parameter int FRAC_BITS = fppid_pkg::FRAC_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  fppid_pkg::req_word_type item,
   input  fppid_pkg::cfg_type      cfg,
   output fppid_pkg::rsp_word_type result
);
   import fppid_pkg::*;

   function automatic logic signed [WORD_WIDTH-1:0] fx_mul(
      input logic signed [WORD_WIDTH-1:0] a,
      input logic signed [WORD_WIDTH-1:0] b
   );
      logic signed [2*WORD_WIDTH-1:0] prod;
      prod = a * b;
      return prod[FRAC_BITS +: WORD_WIDTH];
   endfunction

   logic signed [WORD_WIDTH-1:0] integrator_ff, integrator_in;
   logic signed [WORD_WIDTH-1:0] deriv_ff, deriv_in;
   logic signed [WORD_WIDTH-1:0] windup_ff, windup_in;
   logic signed [WORD_WIDTH-1:0] raw;
   logic signed [WORD_WIDTH-1:0] drive;
   logic                         limited;

   always_comb begin
      integrator_in = integrator_ff + fx_mul(windup_ff, cfg.windup_gain)
                    + fx_mul(item.error_value, cfg.integral_gain);
      deriv_in      = fx_mul(item.measured_value, cfg.filter_input_gain)
                    + fx_mul(deriv_ff, cfg.filter_decay);
      raw           = integrator_in + deriv_in
                    + fx_mul(item.measured_value, cfg.direct_derivative_gain)
                    + fx_mul(item.error_value, cfg.proportional_gain);
      // lower limit wins when limits are crossed
      priority if (raw < cfg.drive_min) begin
         drive   = cfg.drive_min;
         limited = 1'b1;
      end else if (raw > cfg.drive_max) begin
         drive   = cfg.drive_max;
         limited = 1'b1;
      end else begin
         drive   = raw;
         limited = 1'b0;
      end
      windup_in = drive - raw;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integrator_ff <= '0;
         deriv_ff      <= '0;
         windup_ff     <= '0;
      end else if (advance) begin
         integrator_ff <= integrator_in;
         deriv_ff      <= deriv_in;
         windup_ff     <= windup_in;
      end
   end

   assign result.drive   = drive;
   assign result.limited = limited;

endmodule

### hw/rtl/fixed_point_pid_antiwindup.sv
`timescale 1ns / 1ps

// Fixed-point PID controller with back-calculation anti-windup.
// req channel: one word per sample (error_value, measured_value), valid/ready.
// rsp channel: one word per sample (drive, limited), valid/ready, in order.
// csr port: csr_we/csr_index/csr_wdata writes one gain or limit per cycle;
//   write only while no sample is in flight.
// Path: an accepted sample goes into the sample register, then into the
//   result register that drives rsp; a stalled rsp holds it back.
// Throughput: one sample per cycle unless rsp stalls. The result register
//   loads as the sample register advances; the multiply/add/clamp pass
//   between them also updates the integrator/filter/windup state with it.
// Stall: when rsp_ready is low the result holds, the sample register fills,
//   and req_ready drops until the result is taken.
// Reset: drops both valids, zeroes the integrator, filter and windup state,
//   zeroes the gains and opens the drive limits to the full signed range.
module fixed_point_pid_antiwindup #(
   parameter int FRAC_BITS = fppid_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  fppid_pkg::req_word_type             req_word,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output fppid_pkg::rsp_word_type             rsp_word,
   input  logic                                csr_we,
   input  logic [fppid_pkg::CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [fppid_pkg::WORD_WIDTH-1:0]    csr_wdata
);
   import fppid_pkg::*;

   cfg_type      cfg;
   req_word_type smp_ff;
   logic         smp_valid_ff;
   rsp_word_type result;
   rsp_word_type rsp_ff;
   logic         rsp_valid_ff;
   logic         advance;

   assign advance   = smp_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !smp_valid_ff || advance;

   fppid_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   fppid_core #(
      .FRAC_BITS (FRAC_BITS)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (smp_ff),
      .cfg     (cfg),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         smp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            smp_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         smp_ff <= req_word;
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   a_empty_takes: assert property (@(posedge clock) disable iff (reset)
      !smp_valid_ff |-> req_ready)
      else $error("sample register empty but req_ready low");

   a_advance_shows: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("advanced sample did not reach rsp");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("stalled result changed");

   a_full_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      smp_valid_ff && rsp_valid && !rsp_ready |-> !req_ready)
      else $error("sample accepted while pipeline full");

endmodule
